// File: rtl/imu_camera_sync_buffer_assert.svh
// Assertion macros for the IMU / camera sync buffer checker.
// Expects i_clk and i_rst_n to be visible where the macros are used.
`ifndef IMU_CAMERA_SYNC_BUFFER_ASSERT_SVH
`define IMU_CAMERA_SYNC_BUFFER_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted
`define ICSB_CHK_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("icsb check failed");

// Next-cycle implication, ignored while reset is asserted
`define ICSB_CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("icsb check failed");

// Next-cycle implication that also covers reset
`define ICSB_CHK_RESET(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("icsb reset check failed");

`endif

// File: rtl/icsb_pkg.sv
// Shared types and constants for the IMU / camera sync buffer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package icsb_pkg;

    localparam int IN_TDATA_W  = 336;
    localparam int OUT_TDATA_W = 304;

    typedef logic [5:0][31:0] t_vec6;

    typedef struct packed {
        logic [31:0] gap;
        t_vec6       vec;
        logic [62:0] stamp;
    } t_imu_entry;

    typedef struct packed {
        logic [15:0] tag;
        logic [62:0] stamp;
    } t_image_entry;

    typedef enum logic [1:0] {
        ACT_PUSH_IMU   = 2'd0,
        ACT_PUSH_IMAGE = 2'd1,
        ACT_FETCH      = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        ST_NOT_READY   = 3'd0,
        ST_WAITING     = 3'd1,
        ST_DROP_NO_IMU = 3'd2,
        ST_DROP_FEW    = 3'd3,
        ST_IMAGE       = 3'd4,
        ST_IMU         = 3'd5,
        ST_INTERP      = 3'd6,
        ST_OVERFLOW    = 3'd7
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_OUT, S_IMU_RD, S_IMU_CMP, S_IMG_RD, S_IMG_CMP,
        S_F_IMG, S_F_FIRST, S_F_LAST, S_POP_RD, S_POP_CMP, S_POP_ADV,
        S_POP_NEXT, S_INTERP, S_INTERP_WAIT
    } t_seq_state;

    typedef enum logic [2:0] {
        D_IDLE, D_DIV, D_MUL, D_ACC, D_DONE
    } t_interp_state;

    typedef struct packed {
        t_status     status;
        logic        last;
        logic [62:0] stamp;
        t_vec6       vec;
        logic [31:0] gap;
        logic [15:0] tag;
    } t_out_item;

    function automatic t_out_item mk_item(input t_status st, input logic last,
                                          input logic [62:0] stamp, input t_vec6 vec,
                                          input logic [31:0] gap, input logic [15:0] tag);
        t_out_item it;
        it.status = st;
        it.last   = last;
        it.stamp  = stamp;
        it.vec    = vec;
        it.gap    = gap;
        it.tag    = tag;
        return it;
    endfunction

    // Widen an unsigned stamp so that it compares against a signed target
    function automatic logic signed [64:0] ext_stamp(input logic [62:0] s);
        return signed'({2'b00, s});
    endfunction

    // Clamp a non-negative difference to 32 bits
    function automatic logic [31:0] sat32(input logic signed [64:0] d);
        if (d[64:32] != 33'd0) begin
            return 32'hFFFF_FFFF;
        end
        return d[31:0];
    endfunction

endpackage
`default_nettype wire

// File: rtl/icsb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module icsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: rtl/icsb_interp.sv
// Interpolation unit: restoring divider for the Q0.16 weight, then one
// shared multiplier blending the six axes in turn. Uses icsb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module icsb_interp
    import icsb_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    output logic                     o_done,
    input  wire logic signed [64:0]  i_target,
    input  wire logic        [62:0]  i_t1,
    input  wire logic        [62:0]  i_t2,
    input  wire t_vec6               i_v1,
    input  wire t_vec6               i_v2,
    output t_vec6                    o_res
);

    t_interp_state r_state, n_state;
    logic [63:0] r_num, n_num;
    logic [62:0] r_den, n_den;
    logic [15:0] r_c2, n_c2;
    logic [3:0]  r_step, n_step;
    logic [2:0]  r_k, n_k;
    logic signed [49:0] r_prod, n_prod;
    t_vec6       r_res, n_res;

    logic [64:0]        sh;
    logic signed [64:0] num0;
    logic signed [32:0] diff;
    logic signed [49:0] rnd;

    // Hold the state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the datapath registers
    always_ff @(posedge i_clk) begin
        r_num  <= n_num;
        r_den  <= n_den;
        r_c2   <= n_c2;
        r_step <= n_step;
        r_k    <= n_k;
        r_prod <= n_prod;
        r_res  <= n_res;
    end

    // Sequence the divide steps and the blend of each axis
    always_comb begin
        n_state = r_state;
        n_num   = r_num;
        n_den   = r_den;
        n_c2    = r_c2;
        n_step  = r_step;
        n_k     = r_k;
        n_prod  = r_prod;
        n_res   = r_res;
        o_done  = 1'b0;
        sh      = {r_num, 1'b0};
        num0    = i_target - ext_stamp(i_t1);
        diff    = signed'({i_v2[r_k][31], i_v2[r_k]}) - signed'({i_v1[r_k][31], i_v1[r_k]});
        rnd     = (r_prod + 50'sd32768) >>> 16;
        unique case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    n_num   = num0[63:0];
                    n_den   = i_t2 - i_t1;
                    n_c2    = '0;
                    n_step  = '0;
                    n_state = D_DIV;
                end
            end
            D_DIV: begin
                // One quotient bit per cycle
                if (sh >= {2'b00, r_den}) begin
                    n_num = 64'(sh - {2'b00, r_den});
                    n_c2  = {r_c2[14:0], 1'b1};
                end else begin
                    n_num = sh[63:0];
                    n_c2  = {r_c2[14:0], 1'b0};
                end
                n_step = r_step + 4'd1;
                if (r_step == 4'd15) begin
                    n_k     = '0;
                    n_state = D_MUL;
                end
            end
            D_MUL: begin
                // weight times the step between the two samples
                n_prod  = signed'({1'b0, r_c2}) * diff;
                n_state = D_ACC;
            end
            D_ACC: begin
                n_res[r_k] = i_v1[r_k] + rnd[31:0];
                n_k        = r_k + 3'd1;
                if (r_k == 3'd5) begin
                    n_state = D_DONE;
                end else begin
                    n_state = D_MUL;
                end
            end
            D_DONE: begin
                o_done  = 1'b1;
                n_state = D_IDLE;
            end
            default: n_state = D_IDLE;
        endcase
    end

    assign o_res = r_res;

endmodule
`default_nettype wire

// File: rtl/imu_camera_sync_buffer.sv
// IMU / camera measurement sync buffer: an IMU sample queue and an image
// queue, both kept sorted by stamp, aligned by fetch requests.
// Uses icsb_pkg, icsb_ram and icsb_interp.
//
// One item is handled at a time; s_axis_tready is high only while idle, and
// each result is a transfer on the master side that must be taken before
// the work goes on. Both queues are circular buffers in RAM with one read
// and one write per cycle, so an insert walks the queue from the tail,
// reading each entry it moves past and writing it up one place. A fetch
// reads the image head, then the first and last IMU samples to check the
// queues, then pops the IMU samples up to the target one at a time, and for
// an interpolated sample runs 16 divider steps and a multiply and add per
// axis on the shared multiplier. Stores need no clearing after reset. The
// min_imu_samples register is written on the cfg channel.
`timescale 1ns / 1ps
`default_nettype none
module imu_camera_sync_buffer
    import icsb_pkg::*;
#(
    parameter int IMU_DEPTH   = 32,
    parameter int IMAGE_DEPTH = 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // stamp_ns, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z, gap_ns,
    // image_tag, offset_ns, zero fill
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // action
    input  wire logic [1:0]             s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // out_stamp_ns, out_gyro_x, out_gyro_y, out_gyro_z, out_accel_x,
    // out_accel_y, out_accel_z, out_gap_ns, out_image_tag, zero fill
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // status
    output logic [2:0]                  m_axis_tuser,
    output logic                        m_axis_tlast,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [5:0]             i_cfg_data
);

    localparam int IW  = $clog2(IMU_DEPTH);
    localparam int ICW = $clog2(IMU_DEPTH + 1);
    localparam int GW  = $clog2(IMAGE_DEPTH);
    localparam int GCW = $clog2(IMAGE_DEPTH + 1);
    localparam int IMU_W = $bits(t_imu_entry);
    localparam int IMG_W = $bits(t_image_entry);

    function automatic logic [IW-1:0] imu_wrap(input logic [IW:0] s);
        if (s >= (IW+1)'(IMU_DEPTH)) begin
            return IW'(s - (IW+1)'(IMU_DEPTH));
        end
        return s[IW-1:0];
    endfunction

    function automatic logic [GW-1:0] img_wrap(input logic [GW:0] s);
        if (s >= (GW+1)'(IMAGE_DEPTH)) begin
            return GW'(s - (GW+1)'(IMAGE_DEPTH));
        end
        return s[GW-1:0];
    endfunction

    t_seq_state   r_state, n_state, r_ret, n_ret;
    logic [IW-1:0]  r_imu_head, n_imu_head;
    logic [ICW-1:0] r_imu_cnt, n_imu_cnt, r_ij, n_ij;
    logic [GW-1:0]  r_img_head, n_img_head;
    logic [GCW-1:0] r_img_cnt, n_img_cnt, r_gj, n_gj;
    logic [5:0]     r_min;
    logic           r_ov, n_ov;
    t_out_item      r_out, n_out;
    t_imu_entry     r_new, n_new, r_cur, n_cur, r_nxt, n_nxt;
    logic [15:0]    r_new_tag, n_new_tag, r_tag, n_tag;
    logic [30:0]    r_off, n_off;
    logic [62:0]    r_istamp, n_istamp;
    logic signed [64:0] r_target, n_target;

    logic           imu_we, img_we;
    logic [IW-1:0]  imu_waddr, imu_raddr;
    logic [GW-1:0]  img_waddr, img_raddr;
    t_imu_entry     imu_wdata, imu_rdata;
    t_image_entry   img_wdata, img_rdata;
    logic           interp_start;
    logic           interp_done;
    t_vec6          interp_res;

    logic           in_acc;
    logic [ICW-1:0] imu_cm1;
    logic [IW-1:0]  imu_head_p1;
    logic [GW-1:0]  img_head_p1;
    t_imu_entry     head_upd;

    icsb_ram #(.WIDTH(IMU_W), .DEPTH(IMU_DEPTH)) u_imu_ram (
        .i_clk   (i_clk),
        .i_we    (imu_we),
        .i_waddr (imu_waddr),
        .i_wdata (imu_wdata),
        .i_raddr (imu_raddr),
        .o_rdata (imu_rdata)
    );

    icsb_ram #(.WIDTH(IMG_W), .DEPTH(IMAGE_DEPTH)) u_img_ram (
        .i_clk   (i_clk),
        .i_we    (img_we),
        .i_waddr (img_waddr),
        .i_wdata (img_wdata),
        .i_raddr (img_raddr),
        .o_rdata (img_rdata)
    );

    icsb_interp u_interp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (interp_start),
        .o_done   (interp_done),
        .i_target (r_target),
        .i_t1     (r_cur.stamp),
        .i_t2     (r_nxt.stamp),
        .i_v1     (r_cur.vec),
        .i_v2     (r_nxt.vec),
        .o_res    (interp_res)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {1'b0, r_out.tag, r_out.gap, r_out.vec, r_out.stamp};

    assign imu_cm1     = r_imu_cnt - 1'b1;
    assign imu_head_p1 = imu_wrap({1'b0, r_imu_head} + (IW+1)'(1));
    assign img_head_p1 = img_wrap({1'b0, r_img_head} + (GW+1)'(1));

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ret      <= S_IDLE;
            r_ov       <= 1'b0;
            r_imu_head <= '0;
            r_imu_cnt  <= '0;
            r_img_head <= '0;
            r_img_cnt  <= '0;
            r_min      <= 6'd20;
        end else begin
            r_state    <= n_state;
            r_ret      <= n_ret;
            r_ov       <= n_ov;
            r_imu_head <= n_imu_head;
            r_imu_cnt  <= n_imu_cnt;
            r_img_head <= n_img_head;
            r_img_cnt  <= n_img_cnt;
            if (i_cfg_valid && o_cfg_ready) begin
                r_min <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_out     <= n_out;
        r_new     <= n_new;
        r_new_tag <= n_new_tag;
        r_off     <= n_off;
        r_ij      <= n_ij;
        r_gj      <= n_gj;
        r_cur     <= n_cur;
        r_nxt     <= n_nxt;
        r_tag     <= n_tag;
        r_istamp  <= n_istamp;
        r_target  <= n_target;
    end

    // Sequencer: next state, RAM ports and result loading
    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_ov       = r_ov;
        n_out      = r_out;
        n_imu_head = r_imu_head;
        n_imu_cnt  = r_imu_cnt;
        n_img_head = r_img_head;
        n_img_cnt  = r_img_cnt;
        n_new      = r_new;
        n_new_tag  = r_new_tag;
        n_off      = r_off;
        n_ij       = r_ij;
        n_gj       = r_gj;
        n_cur      = r_cur;
        n_nxt      = r_nxt;
        n_tag      = r_tag;
        n_istamp   = r_istamp;
        n_target   = r_target;
        imu_we     = 1'b0;
        imu_waddr  = r_imu_head;
        imu_wdata  = r_new;
        imu_raddr  = r_imu_head;
        img_we     = 1'b0;
        img_waddr  = r_img_head;
        img_wdata  = '{tag: r_new_tag, stamp: r_new.stamp};
        img_raddr  = r_img_head;
        interp_start = 1'b0;
        head_upd   = r_nxt;
        head_upd.gap = sat32(ext_stamp(r_nxt.stamp) - r_target);

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_new.stamp = s_axis_tdata[62:0];
                    n_new.vec   = s_axis_tdata[254:63];
                    n_new.gap   = s_axis_tdata[286:255];
                    n_new_tag   = s_axis_tdata[302:287];
                    n_off       = s_axis_tdata[333:303];
                    unique case (s_axis_tuser)
                        ACT_PUSH_IMU: begin
                            if (r_imu_cnt == ICW'(IMU_DEPTH)) begin
                                n_out   = mk_item(ST_OVERFLOW, 1'b1, '0, '0, '0, '0);
                                n_ov    = 1'b1;
                                n_ret   = S_IDLE;
                                n_state = S_OUT;
                            end else begin
                                n_ij    = r_imu_cnt;
                                n_state = S_IMU_RD;
                            end
                        end
                        ACT_PUSH_IMAGE: begin
                            if (r_img_cnt == GCW'(IMAGE_DEPTH)) begin
                                n_out   = mk_item(ST_OVERFLOW, 1'b1, '0, '0, '0, '0);
                                n_ov    = 1'b1;
                                n_ret   = S_IDLE;
                                n_state = S_OUT;
                            end else begin
                                n_gj    = r_img_cnt;
                                n_state = S_IMG_RD;
                            end
                        end
                        ACT_FETCH: begin
                            if (r_imu_cnt == '0 || r_img_cnt == '0) begin
                                n_out   = mk_item(ST_NOT_READY, 1'b1, '0, '0, '0, '0);
                                n_ov    = 1'b1;
                                n_ret   = S_IDLE;
                                n_state = S_OUT;
                            end else begin
                                img_raddr = r_img_head;
                                n_state   = S_F_IMG;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_OUT: begin
                // Hold the result until the transfer completes
                if (m_axis_tready) begin
                    n_ov    = 1'b0;
                    n_state = r_ret;
                end
            end
            S_IMU_RD: begin
                if (r_ij == '0) begin
                    imu_we    = 1'b1;
                    imu_waddr = r_imu_head;
                    n_imu_cnt = r_imu_cnt + 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    imu_raddr = imu_wrap({1'b0, r_imu_head} + {1'b0, IW'(r_ij - 1'b1)});
                    n_state   = S_IMU_CMP;
                end
            end
            S_IMU_CMP: begin
                // Move a later entry up one place, or drop the new one in
                imu_we    = 1'b1;
                imu_waddr = imu_wrap({1'b0, r_imu_head} + {1'b0, r_ij[IW-1:0]});
                if (imu_rdata.stamp > r_new.stamp) begin
                    imu_wdata = imu_rdata;
                    n_ij      = r_ij - 1'b1;
                    n_state   = S_IMU_RD;
                end else begin
                    n_imu_cnt = r_imu_cnt + 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_IMG_RD: begin
                if (r_gj == '0) begin
                    img_we    = 1'b1;
                    img_waddr = r_img_head;
                    n_img_cnt = r_img_cnt + 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    img_raddr = img_wrap({1'b0, r_img_head} + {1'b0, GW'(r_gj - 1'b1)});
                    n_state   = S_IMG_CMP;
                end
            end
            S_IMG_CMP: begin
                img_we    = 1'b1;
                img_waddr = img_wrap({1'b0, r_img_head} + {1'b0, r_gj[GW-1:0]});
                if (img_rdata.stamp > r_new.stamp) begin
                    img_wdata = img_rdata;
                    n_gj      = r_gj - 1'b1;
                    n_state   = S_IMG_RD;
                end else begin
                    n_img_cnt = r_img_cnt + 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_F_IMG: begin
                n_istamp  = img_rdata.stamp;
                n_tag     = img_rdata.tag;
                n_target  = ext_stamp(img_rdata.stamp) + {{34{r_off[30]}}, r_off};
                imu_raddr = r_imu_head;
                n_state   = S_F_FIRST;
            end
            S_F_FIRST: begin
                if (ext_stamp(imu_rdata.stamp) >= r_target) begin
                    n_img_head = img_head_p1;
                    n_img_cnt  = r_img_cnt - 1'b1;
                    n_out   = mk_item(ST_DROP_NO_IMU, 1'b1, r_istamp, '0, '0, r_tag);
                    n_ov    = 1'b1;
                    n_ret   = S_IDLE;
                    n_state = S_OUT;
                end else begin
                    imu_raddr = imu_wrap({1'b0, r_imu_head} + {1'b0, imu_cm1[IW-1:0]});
                    n_state   = S_F_LAST;
                end
            end
            S_F_LAST: begin
                n_ov    = 1'b1;
                n_state = S_OUT;
                n_ret   = S_IDLE;
                if (ext_stamp(imu_rdata.stamp) < r_target) begin
                    n_out = mk_item(ST_WAITING, 1'b1, '0, '0, '0, '0);
                end else if (7'(r_imu_cnt) < {1'b0, r_min}) begin
                    n_img_head = img_head_p1;
                    n_img_cnt  = r_img_cnt - 1'b1;
                    n_out = mk_item(ST_DROP_FEW, 1'b1, r_istamp, '0, '0, r_tag);
                end else begin
                    n_img_head = img_head_p1;
                    n_img_cnt  = r_img_cnt - 1'b1;
                    n_out = mk_item(ST_IMAGE, 1'b0, r_istamp, '0, '0, r_tag);
                    n_ret = S_POP_RD;
                end
            end
            S_POP_RD: begin
                imu_raddr = r_imu_head;
                n_state   = S_POP_CMP;
            end
            S_POP_CMP: begin
                n_nxt   = imu_rdata;
                n_state = S_POP_ADV;
            end
            S_POP_ADV: begin
                // Pop the sample known to lie at or before the target
                n_cur      = r_nxt;
                n_imu_head = imu_head_p1;
                n_imu_cnt  = imu_cm1;
                if (imu_cm1 == '0) begin
                    n_out   = mk_item(ST_IMU, 1'b1, r_nxt.stamp, r_nxt.vec, r_nxt.gap, '0);
                    n_ov    = 1'b1;
                    n_ret   = S_IDLE;
                    n_state = S_OUT;
                end else begin
                    imu_raddr = imu_head_p1;
                    n_state   = S_POP_NEXT;
                end
            end
            S_POP_NEXT: begin
                n_nxt   = imu_rdata;
                n_ov    = 1'b1;
                n_state = S_OUT;
                if (ext_stamp(imu_rdata.stamp) <= r_target) begin
                    n_out = mk_item(ST_IMU, 1'b0, r_cur.stamp, r_cur.vec, r_cur.gap, '0);
                    n_ret = S_POP_ADV;
                end else if (ext_stamp(r_cur.stamp) < r_target) begin
                    n_out = mk_item(ST_IMU, 1'b0, r_cur.stamp, r_cur.vec, r_cur.gap, '0);
                    n_ret = S_INTERP;
                end else begin
                    n_out = mk_item(ST_IMU, 1'b1, r_cur.stamp, r_cur.vec, r_cur.gap, '0);
                    n_ret = S_IDLE;
                end
            end
            S_INTERP: begin
                interp_start = 1'b1;
                n_state      = S_INTERP_WAIT;
            end
            S_INTERP_WAIT: begin
                // Emit the sample at the target and shorten the next interval
                if (interp_done) begin
                    imu_we    = 1'b1;
                    imu_waddr = r_imu_head;
                    imu_wdata = head_upd;
                    n_out   = mk_item(ST_INTERP, 1'b1, r_target[62:0], interp_res,
                                      sat32(r_target - ext_stamp(r_cur.stamp)), '0);
                    n_ov    = 1'b1;
                    n_ret   = S_IDLE;
                    n_state = S_OUT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/icsb_checker.sv
// Port-level checks for the IMU / camera sync buffer, bound to the top.
// Uses icsb_pkg and imu_camera_sync_buffer_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "imu_camera_sync_buffer_assert.svh"
module icsb_assert_checker
    import icsb_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic [2:0]             m_axis_tuser,
    input wire logic                   m_axis_tlast
);

    // A stalled result holds
    `ICSB_CHK_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    // No new item is taken while a result is pending
    `ICSB_CHK_NOW(a_busy_on_out, m_axis_tvalid, !s_axis_tready)
    // A result that is not the last of its run keeps the block busy
    `ICSB_CHK_NEXT(a_run_busy, m_axis_tvalid && m_axis_tready && !m_axis_tlast,
        !s_axis_tready)
    // Reset leaves the block idle with no result
    `ICSB_CHK_RESET(a_reset_idle, !i_rst_n, !m_axis_tvalid && s_axis_tready)

endmodule

bind imu_camera_sync_buffer icsb_assert_checker u_icsb_checker (.*);
`default_nettype wire

// File: tb/icsb_checker.sv
// Checker for the IMU / camera sync buffer: watches the stream and config
// channels, predicts each result and compares it with the master side.
// Uses icsb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module icsb_checker
    import icsb_pkg::*;
#(
    parameter int IMU_DEPTH   = 32,
    parameter int IMAGE_DEPTH = 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    input  wire logic                   s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic [1:0]             s_axis_tuser,
    input  wire logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    input  wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  wire logic [2:0]             m_axis_tuser,
    input  wire logic                   m_axis_tlast,
    input  wire logic                   i_cfg_valid,
    input  wire logic                   i_cfg_ready,
    input  wire logic [5:0]             i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending
);

    localparam int DUE_DEPTH = 64;

    // Shadow copy of both queues and the sample-count register
    logic [62:0] imu_stamp [IMU_DEPTH];
    t_vec6       imu_vec   [IMU_DEPTH];
    logic [31:0] imu_gap   [IMU_DEPTH];
    int          imu_n;
    logic [62:0] img_stamp [IMAGE_DEPTH];
    logic [15:0] img_tag   [IMAGE_DEPTH];
    int          img_n;
    logic [5:0]  min_samples;

    // Ring of predicted results still to be seen on the master side
    t_out_item   due_buf [DUE_DEPTH];
    int          due_wr;
    int          due_rd;
    int          due_cnt;

    function automatic logic [31:0] clamp32(input logic [65:0] d);
        return (d[65:32] != '0) ? 32'hFFFF_FFFF : d[31:0];
    endfunction

    // Weighted sum of two Q16.16 values with Q0.16 weights, rounded
    function automatic logic [31:0] mix(input logic [31:0] v1, input logic [31:0] v2,
                                        input longint c1, input longint c2);
        longint acc;
        acc = c1 * longint'($signed(v1)) + c2 * longint'($signed(v2));
        return 32'((acc + 32768) >>> 16);
    endfunction

    task automatic add_result(input t_status st, input logic [62:0] stamp,
                              input t_vec6 vec, input logic [31:0] gap,
                              input logic [15:0] tag);
        t_out_item it;
        it.status = st;
        it.last   = 1'b0;
        it.stamp  = stamp;
        it.vec    = vec;
        it.gap    = gap;
        it.tag    = tag;
        due_buf[due_wr] = it;
        due_wr = (due_wr + 1) % DUE_DEPTH;
        due_cnt++;
    endtask

    task automatic pop_image();
        for (int i = 0; i < IMAGE_DEPTH - 1; i++) begin
            img_stamp[i] = img_stamp[i+1];
            img_tag[i]   = img_tag[i+1];
        end
        img_n--;
    endtask

    task automatic run_fetch(input logic [30:0] off);
        logic signed [65:0] tgt;
        logic [62:0]        istamp, t1, t2;
        logic [15:0]        tag;
        logic [65:0]        num, den;
        logic [16:0]        c2;
        t_vec6              v1, vi;
        int                 n;
        if (imu_n == 0 || img_n == 0) begin
            add_result(ST_NOT_READY, '0, '0, '0, '0);
            return;
        end
        istamp = img_stamp[0];
        tag    = img_tag[0];
        tgt    = $signed({3'b000, istamp}) + $signed({{35{off[30]}}, off});
        if ($signed({3'b000, imu_stamp[0]}) >= tgt) begin
            pop_image();
            add_result(ST_DROP_NO_IMU, istamp, '0, '0, tag);
            return;
        end
        if ($signed({3'b000, imu_stamp[imu_n-1]}) < tgt) begin
            add_result(ST_WAITING, '0, '0, '0, '0);
            return;
        end
        if (imu_n < int'(min_samples)) begin
            pop_image();
            add_result(ST_DROP_FEW, istamp, '0, '0, tag);
            return;
        end
        pop_image();
        add_result(ST_IMAGE, istamp, '0, '0, tag);
        n = 0;
        while (n < imu_n && $signed({3'b000, imu_stamp[n]}) <= tgt) begin
            add_result(ST_IMU, imu_stamp[n], imu_vec[n], imu_gap[n], '0);
            n++;
        end
        t1 = imu_stamp[n-1];
        v1 = imu_vec[n-1];
        // Advance the sample queue past the popped run
        for (int i = 0; i + n < IMU_DEPTH; i++) begin
            imu_stamp[i] = imu_stamp[i+n];
            imu_vec[i]   = imu_vec[i+n];
            imu_gap[i]   = imu_gap[i+n];
        end
        imu_n -= n;
        if ($signed({3'b000, t1}) < tgt && imu_n > 0) begin
            t2  = imu_stamp[0];
            num = 66'(tgt) - {3'b000, t1};
            den = {3'b000, t2} - {3'b000, t1};
            c2  = '0;
            for (int i = 0; i < 16; i++) begin
                num = num << 1;
                c2  = c2 << 1;
                if (num >= den) begin
                    num    = num - den;
                    c2[0]  = 1'b1;
                end
            end
            for (int i = 0; i < 6; i++) begin
                vi[i] = mix(v1[i], imu_vec[0][i], 65536 - longint'(c2), longint'(c2));
            end
            add_result(ST_INTERP, tgt[62:0], vi, clamp32(66'(tgt) - {3'b000, t1}), '0);
            imu_gap[0] = clamp32({3'b000, t2} - 66'(tgt));
        end
    endtask

    task automatic predict(input logic [IN_TDATA_W-1:0] d, input logic [1:0] act);
        logic [62:0] stamp;
        int          pos, start;
        start = due_cnt;
        stamp = d[62:0];
        case (t_action'(act))
            ACT_PUSH_IMU: begin
                if (imu_n >= IMU_DEPTH) begin
                    add_result(ST_OVERFLOW, '0, '0, '0, '0);
                end else begin
                    pos = 0;
                    while (pos < imu_n && imu_stamp[pos] <= stamp) pos++;
                    for (int i = imu_n; i > pos; i--) begin
                        imu_stamp[i] = imu_stamp[i-1];
                        imu_vec[i]   = imu_vec[i-1];
                        imu_gap[i]   = imu_gap[i-1];
                    end
                    imu_stamp[pos] = stamp;
                    for (int i = 0; i < 6; i++) imu_vec[pos][i] = d[63+32*i +: 32];
                    imu_gap[pos] = d[286:255];
                    imu_n++;
                end
            end
            ACT_PUSH_IMAGE: begin
                if (img_n >= IMAGE_DEPTH) begin
                    add_result(ST_OVERFLOW, '0, '0, '0, '0);
                end else begin
                    pos = 0;
                    while (pos < img_n && img_stamp[pos] <= stamp) pos++;
                    for (int i = img_n; i > pos; i--) begin
                        img_stamp[i] = img_stamp[i-1];
                        img_tag[i]   = img_tag[i-1];
                    end
                    img_stamp[pos] = stamp;
                    img_tag[pos]   = d[302:287];
                    img_n++;
                end
            end
            ACT_FETCH: run_fetch(d[333:303]);
            default: ;
        endcase
        if (due_cnt > start) due_buf[(due_wr + DUE_DEPTH - 1) % DUE_DEPTH].last = 1'b1;
    endtask

    task automatic compare(input logic [OUT_TDATA_W-1:0] d, input logic [2:0] st,
                           input logic lst);
        t_out_item e;
        string     vname [6];
        vname = '{"out_gyro_x", "out_gyro_y", "out_gyro_z",
                  "out_accel_x", "out_accel_y", "out_accel_z"};
        if (due_cnt == 0) begin
            $error("unexpected result: status %0d", st);
            o_fail_count++;
            return;
        end
        e = due_buf[due_rd];
        due_rd = (due_rd + 1) % DUE_DEPTH;
        due_cnt--;
        if (st !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, st);
            o_fail_count++;
        end
        if (lst !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, lst);
            o_fail_count++;
        end
        if (d[62:0] !== e.stamp) begin
            $error("out_stamp_ns: expected %0d, got %0d", e.stamp, d[62:0]);
            o_fail_count++;
        end
        for (int i = 0; i < 6; i++) begin
            if (d[63+32*i +: 32] !== e.vec[i]) begin
                $error("%s: expected %0h, got %0h", vname[i], e.vec[i], d[63+32*i +: 32]);
                o_fail_count++;
            end
        end
        if (d[286:255] !== e.gap) begin
            $error("out_gap_ns: expected %0d, got %0d", e.gap, d[286:255]);
            o_fail_count++;
        end
        if (d[302:287] !== e.tag) begin
            $error("out_image_tag: expected %0h, got %0h", e.tag, d[302:287]);
            o_fail_count++;
        end
    endtask

    // Track transfers on every channel
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            imu_n        = 0;
            img_n        = 0;
            min_samples  = 6'd20;
            o_fail_count = 0;
            due_wr       = 0;
            due_rd       = 0;
            due_cnt      = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) compare(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            if (i_cfg_valid && i_cfg_ready) min_samples = i_cfg_data;
            if (s_axis_tvalid && s_axis_tready) predict(s_axis_tdata, s_axis_tuser);
        end
        o_pending = due_cnt;
    end

endmodule
`default_nettype wire

// File: tb/imu_camera_sync_buffer_test.sv
// Top of the IMU / camera sync buffer testbench: clock, reset, stimulus,
// receiver stalls and verdict. Uses icsb_pkg, icsb_checker and the block.
`timescale 1ns / 1ps
`default_nettype none
module imu_camera_sync_buffer_test;
    import icsb_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam logic [62:0] STAMP_MAX = {63{1'b1}};

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]             s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [2:0]             m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [5:0]             i_cfg_data = '0;
    int                     fail_count;
    int                     pending;
    int                     send_idle = 0;
    int                     recv_idle = 0;
    int                     hold_req  = 0;
    int                     quiet     = 0;

    imu_camera_sync_buffer i_dut (.*);

    icsb_checker i_chk (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested
    int hold_seen = 0;
    int hold_left = 0;
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = 1500;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Watchdog on cycles with no transfer at all
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic logic [31:0] rnd32();
        return $urandom;
    endfunction

    function automatic logic [62:0] rnd63();
        return 63'({$urandom, $urandom});
    endfunction

    task automatic send(input t_action act, input logic [62:0] stamp, input t_vec6 vec,
                        input logic [31:0] gap, input logic [15:0] tag,
                        input logic [30:0] off);
        logic [IN_TDATA_W-1:0] d;
        d = '0;
        d[62:0] = stamp;
        for (int i = 0; i < 6; i++) d[63+32*i +: 32] = vec[i];
        d[286:255] = gap;
        d[302:287] = tag;
        d[333:303] = off;
        s_axis_tdata  <= d;
        s_axis_tuser  <= act;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic rnd_vec(output t_vec6 v);
        for (int i = 0; i < 6; i++) v[i] = rnd32();
    endtask

    task automatic fetch(input logic [30:0] off);
        send(ACT_FETCH, rnd63(), '0, '0, '0, off);
    endtask

    // Write the sample-count register once all results are in and the block is quiet
    task automatic set_min(input logic [5:0] v);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        i_cfg_data  <= v;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // One capture: a run of IMU samples, an image inside it, then a fetch
    task automatic frame(inout logic [63:0] tnow, input int nsamp);
        t_vec6       v;
        logic [63:0] step, ts;
        int          span;
        step = ($urandom_range(9) == 0) ? {$urandom_range(1, 7), rnd32()}
                                        : 64'($urandom_range(1000, 5000000));
        for (int k = 0; k < nsamp; k++) begin
            rnd_vec(v);
            ts = tnow + step * k;
            case ($urandom_range(11))
                0: ts = tnow + step * (k - 1);
                1: ts = ts - $urandom_range(0, 500);
                default: ;
            endcase
            send(ACT_PUSH_IMU, ts[62:0], v, rnd32(), '0, '0);
        end
        ts   = tnow + step * (nsamp > 2 ? nsamp - 2 : 0) + $urandom_range(0, 999);
        send(ACT_PUSH_IMAGE, ts[62:0], '0, '0, 16'($urandom), '0);
        span = ($urandom_range(5) == 0) ? 1000000000 : 500;
        fetch(31'($urandom_range(0, 2 * span) - span));
        tnow = tnow + step * nsamp;
    endtask

    // Any action with unrelated content
    task automatic noise();
        t_vec6 v;
        rnd_vec(v);
        send(t_action'($urandom_range(3)), rnd63(), v, rnd32(), 16'($urandom),
             31'($urandom_range(0, 2000000000) - 1000000000));
    endtask

    initial begin
        t_vec6       vmin, vmax;
        logic [63:0] tnow;
        logic [5:0]  mins [5];
        for (int i = 0; i < 6; i++) begin
            vmin[i] = 32'h8000_0000;
            vmax[i] = 32'h7FFF_FFFF;
        end
        mins = '{6'd20, 6'd0, 6'd62, 6'd5, 6'd1};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty fetch, extremes, every drop path, waiting, saturating gaps
        fetch('0);
        send(ACT_PUSH_IMU, STAMP_MAX, vmin, 32'hFFFF_FFFF, '0, '0);
        send(ACT_PUSH_IMU, '0, vmax, '0, '0, '0);
        send(ACT_PUSH_IMAGE, '0, '0, '0, 16'hFFFF, '0);
        fetch('0);
        send(ACT_PUSH_IMAGE, 63'd5, '0, '0, '0, '0);
        fetch('0);
        set_min(6'd0);
        send(ACT_PUSH_IMAGE, 63'd100, '0, '0, 16'h1234, '0);
        fetch(-31'sd1000000000);
        send(ACT_PUSH_IMAGE, STAMP_MAX, '0, '0, 16'h0001, '0);
        fetch(31'sd1000000000);
        fetch(-31'sd1000000000);
        send(t_action'(2'd3), rnd63(), vmax, rnd32(), 16'hAAAA, '0);
        for (int i = 0; i < 9; i++) begin
            send(ACT_PUSH_IMAGE, 63'(i), '0, '0, 16'(i), '0);
        end
        repeat (8) fetch('0);

        // Random phases over idling modes and register settings
        tnow = 64'($urandom_range(0, 100000));
        for (int p = 0; p < 5; p++) begin
            set_min(mins[p]);
            case (p % 4)
                0: begin send_idle = 0;  recv_idle = 0;  end
                1: begin send_idle = 63; recv_idle = 0;  end
                2: begin send_idle = 0;  recv_idle = 63; end
                default: begin send_idle = 32; recv_idle = 32; end
            endcase
            if (p == 3) hold_req++;
            for (int n = 0; n < 90; ) begin
                if ($urandom_range(5) == 0) begin
                    noise();
                    n++;
                end else begin
                    int ns;
                    ns = (mins[p] > 28) ? $urandom_range(2, 8)
                                        : int'(mins[p]) + $urandom_range(1, 3);
                    frame(tnow, ns);
                    n += ns + 2;
                end
            end
        end

        // Drain, allow the block to settle, then give the verdict
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
